### design/mcoc_pkg.sv
package mcoc_pkg;

  localparam int COST_W = 35;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_SHORT    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_LATCH,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

endpackage

### design/matrix_chain_order_cost_unit.sv
// Matrix chain cost unit. Dimensions d0, d1, ... arrive one per request on the req channel,
// and the request with last_dim set closes the chain; the unit then returns one result on
// the res channel: the least number of scalar multiplications needed to multiply the chain,
// or an error code (1 for fewer than two dimensions, 2 when more than MAX_DIMS dimensions
// arrived) with a cost of 0. Dimensions are taken one per cycle while loading. After the
// last one the unit fills a cost table held in a two-read-port memory, span by span, and
// takes no request until the result has been handed to the output register. For a chain
// of n dimensions the fill visits every pair of end points (i, j) with 1 <= i < j <= n-1;
// a pair issues its (j - i) split points into the split-point pipeline between setup and
// drain, and its cost is written back once the pipeline is empty. Chains of two or fewer
// dimensions, and overflowed chains, skip the fill and go straight to the output state.
module matrix_chain_order_cost_unit #(
  parameter int MAX_DIMS = 32,
  parameter int DIM_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [DIM_BITS-1:0]             dim_value,
  input  logic                            last_dim,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [mcoc_pkg::COST_W-1:0]     min_cost,
  output logic [1:0]                      error_code
);

  localparam int CW  = mcoc_pkg::COST_W;
  localparam int IW  = $clog2(MAX_DIMS);
  localparam int NW  = $clog2(MAX_DIMS + 1);
  localparam int AW  = 2 * IW;
  localparam int CD  = 1 << AW;
  localparam int PW1 = 2 * DIM_BITS;
  localparam int PW2 = 3 * DIM_BITS;
  localparam int PWX = (PW2 > CW) ? PW2 : CW + 1;

  mcoc_pkg::state_t state, state_next;

  logic [NW-1:0]       dim_count;
  logic                overflow_seen;

  logic [DIM_BITS-1:0] dim_mem [MAX_DIMS];
  logic [CW-1:0]       cost_mem [CD];

  logic [DIM_BITS-1:0] dim_rd_a, dim_rd_b;
  logic [CW-1:0]       cost_rd_a, cost_rd_b;

  logic [IW-1:0]       i, j, k;
  logic [DIM_BITS-1:0] da, dj;
  logic [CW-1:0]       best;
  logic [CW-1:0]       pend_cost;
  logic [1:0]          pend_err;

  logic                s1_v, s1_l0, s1_r0;
  logic                s2_v, s3_v;
  logic [PW1-1:0]      s2_p1;
  logic [PW2-1:0]      s3_p2;
  logic [CW-1:0]       s2_cs, s3_cs;

  logic                accept, out_free, pipe_empty, j_end, last_pair;
  logic                cnt_full, ovf_new;
  logic [NW-1:0]       n_new;
  logic                dim_we, cost_we, issue;
  logic [IW-1:0]       dim_addr_a;
  logic [AW-1:0]       cost_addr_a, cost_addr_b;

  logic [CW-1:0]       cl, cr;
  logic [CW:0]         sum1, sum3;
  logic [PWX-1:0]      p2_ext;
  logic [CW-1:0]       p2_sat, cand;

  assign accept     = req_valid && !req_stall;
  assign out_free   = !res_valid || !res_stall;
  assign pipe_empty = !s1_v && !s2_v && !s3_v;
  assign j_end      = (NW'(j) == dim_count - NW'(1));
  assign last_pair  = j_end && (i == IW'(1));
  assign cnt_full   = (dim_count == NW'(MAX_DIMS));
  assign n_new      = cnt_full ? dim_count : dim_count + NW'(1);
  assign ovf_new    = overflow_seen || cnt_full;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mcoc_pkg::ST_LOAD: begin
        if (accept && last_dim) begin
          if (!ovf_new && n_new > NW'(2)) begin
            state_next = mcoc_pkg::ST_SETUP;
          end else begin
            state_next = mcoc_pkg::ST_OUT;
          end
        end
      end
      mcoc_pkg::ST_SETUP: state_next = mcoc_pkg::ST_LATCH;
      mcoc_pkg::ST_LATCH: state_next = mcoc_pkg::ST_RUN;
      mcoc_pkg::ST_RUN: begin
        if (k == j - IW'(1)) begin
          state_next = mcoc_pkg::ST_DRAIN;
        end
      end
      mcoc_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = last_pair ? mcoc_pkg::ST_OUT : mcoc_pkg::ST_SETUP;
        end
      end
      mcoc_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = mcoc_pkg::ST_LOAD;
        end
      end
      default: state_next = mcoc_pkg::ST_LOAD;
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    req_stall   = (state != mcoc_pkg::ST_LOAD);
    issue       = (state == mcoc_pkg::ST_RUN);
    cost_we     = (state == mcoc_pkg::ST_DRAIN) && pipe_empty;
    dim_we      = accept && !cnt_full;
    dim_addr_a  = issue ? k : i - IW'(1);
    cost_addr_a = {i, k};
    cost_addr_b = {k + IW'(1), j};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mcoc_pkg::ST_LOAD;
      dim_count     <= '0;
      overflow_seen <= 1'b0;
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      s3_v          <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      s1_v  <= issue;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      if (accept) begin
        dim_count     <= n_new;
        overflow_seen <= ovf_new;
      end else if (state == mcoc_pkg::ST_OUT && out_free) begin
        dim_count     <= '0;
        overflow_seen <= 1'b0;
      end
      if (state == mcoc_pkg::ST_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Memories: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (dim_we) begin
      dim_mem[dim_count[IW-1:0]] <= dim_value;
    end
    dim_rd_a <= dim_mem[dim_addr_a];
    dim_rd_b <= dim_mem[j];
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[{i, j}] <= best;
    end
    cost_rd_a <= cost_mem[cost_addr_a];
    cost_rd_b <= cost_mem[cost_addr_b];
  end

  // Diagonal entries are zero and are never stored; the flags mask those reads.
  assign cl   = s1_l0 ? '0 : cost_rd_a;
  assign cr   = s1_r0 ? '0 : cost_rd_b;
  assign sum1 = {1'b0, cl} + {1'b0, cr};

  assign p2_ext = PWX'(s3_p2);
  assign p2_sat = (p2_ext > PWX'(mcoc_pkg::COST_MAX)) ? mcoc_pkg::COST_MAX : p2_ext[CW-1:0];
  assign sum3   = {1'b0, s3_cs} + {1'b0, p2_sat};
  assign cand   = sum3[CW] ? mcoc_pkg::COST_MAX : sum3[CW-1:0];

  always_ff @(posedge clk) begin
    s1_l0 <= (k == i);
    s1_r0 <= (k + IW'(1) == j);
    s2_p1 <= PW1'(da) * PW1'(dim_rd_a);
    s2_cs <= sum1[CW] ? mcoc_pkg::COST_MAX : sum1[CW-1:0];
    s3_p2 <= PW2'(s2_p1) * PW2'(dj);
    s3_cs <= s2_cs;

    case (state)
      mcoc_pkg::ST_LOAD: begin
        if (accept && last_dim) begin
          i         <= IW'(1);
          j         <= IW'(2);
          pend_cost <= '0;
          if (ovf_new) begin
            pend_err <= mcoc_pkg::ERR_OVERFLOW;
          end else if (n_new < NW'(2)) begin
            pend_err <= mcoc_pkg::ERR_SHORT;
          end else begin
            pend_err <= mcoc_pkg::ERR_NONE;
          end
        end
      end
      mcoc_pkg::ST_SETUP: begin
        k    <= i;
        best <= mcoc_pkg::COST_MAX;
      end
      mcoc_pkg::ST_LATCH: begin
        da <= dim_rd_a;
        dj <= dim_rd_b;
      end
      mcoc_pkg::ST_RUN: begin
        k <= k + IW'(1);
      end
      mcoc_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          if (last_pair) begin
            pend_cost <= best;
          end else if (j_end) begin
            // Start the next span length at the left end of the chain.
            i <= IW'(1);
            j <= j - i + IW'(2);
          end else begin
            i <= i + IW'(1);
            j <= j + IW'(1);
          end
        end
      end
      default: begin
      end
    endcase

    if (s3_v && cand < best) begin
      best <= cand;
    end

    if (state == mcoc_pkg::ST_OUT && out_free) begin
      min_cost   <= pend_cost;
      error_code <= pend_err;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    dim_count <= NW'(MAX_DIMS))
    else $error("dimension count exceeds the store depth");

  a_split_range: assert property (@(posedge clk) disable iff (rst)
    state == mcoc_pkg::ST_RUN |-> (k >= i && k < j))
    else $error("split point outside the current span");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    state == mcoc_pkg::ST_SETUP |-> (i != '0 && i < j && NW'(j) < dim_count))
    else $error("span end points out of order or beyond the chain");

  a_result_clear: assert property (@(posedge clk) disable iff (rst)
    (state == mcoc_pkg::ST_OUT && out_free) |=>
      (dim_count == '0 && !overflow_seen && res_valid))
    else $error("chain state not cleared when the result was issued");
`endif

endmodule
